>>> hw/rtl/ufne_pkg.sv
// Shared types, constants and helpers for the URL form name encoder.
// No dependencies; used by every module of the block.

package ufne_pkg;

   // One output byte of the encoded text
   typedef logic [7:0] byte_type;

   // Work record handed from the classifier to the serializer:
   // count is the number of valid bytes (1 to 3), sent from index 0 up.
   typedef struct packed {
      logic [1:0]          count;
      logic [2:0][7:0]     bytes;
   } entry_type;

   // Queue status seen by the classifier and the serializer
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Characters that the encoder emits
   localparam byte_type CHAR_PLUS    = 8'h2B;
   localparam byte_type CHAR_PERCENT = 8'h25;

   // Upper-case hex digit for a nibble
   function automatic byte_type hex_digit(logic [3:0] v);
      byte_type digit;
      if (v < 4'd10) begin
         digit = 8'h30 + {4'h0, v};
      end else begin
         digit = 8'h37 + {4'h0, v};
      end
      return digit;
   endfunction

endpackage

>>> hw/rtl/ufne_front.sv
// Front stage: accepts input bytes, classifies them, keeps the run flags
// and builds one work record per byte. Depends on ufne_pkg.

module ufne_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last_byte,
   input  ufne_pkg::queue_status_type  q_status,
   output logic                        q_push,
   output ufne_pkg::entry_type         q_entry
);

   localparam logic [7:0] CHAR_ACUTE   = 8'hB4;
   localparam logic [7:0] CHAR_APOS    = 8'h27;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_QUEST   = 8'h3F;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK  = 8'h5D;

   logic sep_pending_ff, sep_pending_in;
   logic plus_emitted_ff, plus_emitted_in;
   logic started_ff, started_in;

   logic       accept;
   logic [7:0] c;
   logic       is_crlf, is_sep, is_esc, is_blank;
   ufne_pkg::entry_type entry;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Map the acute accent to an apostrophe, then classify
   always_comb begin
      c        = (req_data_byte == CHAR_ACUTE) ? CHAR_APOS : req_data_byte;
      is_crlf  = (c == CHAR_CR) || (c == CHAR_LF);
      is_sep   = (c == CHAR_QUEST) || (c == ufne_pkg::CHAR_PLUS) || (c == CHAR_EQUAL);
      is_esc   = (c == 8'h00) || c[7] ||
                 (c == ufne_pkg::CHAR_PERCENT) || (c == CHAR_AMP) ||
                 (c == CHAR_COLON) || (c == CHAR_QUOTE) || (c == CHAR_APOS) ||
                 (c == CHAR_LPAREN) || (c == CHAR_RPAREN) ||
                 (c == CHAR_LBRACE) || (c == CHAR_RBRACE) ||
                 (c == CHAR_LBRACK) || (c == CHAR_RBRACK);
      is_blank = (c == CHAR_SPACE) || (c == CHAR_UNDER);
   end

   // Build the output record and the next flag values
   always_comb begin
      entry           = '0;
      sep_pending_in  = sep_pending_ff;
      plus_emitted_in = plus_emitted_ff;
      priority if (is_crlf) begin
         entry.count     = 2'd1;
         entry.bytes[0]  = c;
         sep_pending_in  = 1'b0;
         plus_emitted_in = 1'b0;
      end else if (is_sep) begin
         sep_pending_in  = 1'b1;
      end else if (is_esc) begin
         entry.count     = 2'd3;
         entry.bytes[0]  = ufne_pkg::CHAR_PERCENT;
         entry.bytes[1]  = ufne_pkg::hex_digit(c[7:4]);
         entry.bytes[2]  = ufne_pkg::hex_digit(c[3:0]);
         plus_emitted_in = 1'b0;
      end else if (is_blank) begin
         // a blank swallows the pending separator; collapse runs
         sep_pending_in  = 1'b0;
         plus_emitted_in = 1'b1;
         if (!plus_emitted_ff) begin
            entry.count    = 2'd1;
            entry.bytes[0] = ufne_pkg::CHAR_PLUS;
         end
      end else begin
         sep_pending_in  = 1'b0;
         plus_emitted_in = 1'b0;
         if (sep_pending_ff && started_ff) begin
            entry.count    = 2'd2;
            entry.bytes[0] = ufne_pkg::CHAR_PLUS;
            entry.bytes[1] = c;
         end else begin
            entry.count    = 2'd1;
            entry.bytes[0] = c;
         end
      end
      started_in = started_ff || (entry.count != 2'd0);
   end

   // Drop records that carry no bytes
   assign q_push  = accept && (entry.count != 2'd0);
   assign q_entry = entry;

   // Advance the flags on each transfer; clear them after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_pending_ff  <= 1'b0;
         plus_emitted_ff <= 1'b0;
         started_ff      <= 1'b0;
      end else if (accept) begin
         if (req_last_byte) begin
            sep_pending_ff  <= 1'b0;
            plus_emitted_ff <= 1'b0;
            started_ff      <= 1'b0;
         end else begin
            sep_pending_ff  <= sep_pending_in;
            plus_emitted_ff <= plus_emitted_in;
            started_ff      <= started_in;
         end
      end
   end

endmodule

>>> hw/rtl/ufne_queue.sv
// Small first-in first-out queue of work records between front and back.
// Depends on ufne_pkg.

module ufne_queue #(
   parameter int unsigned QueueDepth = ufne_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ufne_pkg::entry_type         push_entry,
   input  logic                        pop,
   output ufne_pkg::entry_type         head_entry,
   output ufne_pkg::queue_status_type  status
);

   localparam int unsigned PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CountWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(QueueDepth - 1);
   localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(QueueDepth);

   ufne_pkg::entry_type    mem_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);
   assign head_entry   = mem_ff[rd_ptr_ff];

   // Wrap pointers and track the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store records; payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/ufne_back.sv
// Back stage: walks the head record byte by byte into the result register.
// Depends on ufne_pkg.

module ufne_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ufne_pkg::queue_status_type  q_status,
   input  ufne_pkg::entry_type         q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run
);

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;

   logic load_ok, take, at_last;

   // Load a new byte when the result register is free or being drained
   assign load_ok = !rsp_valid_ff || rsp_ready;
   assign take    = load_ok && !q_status.empty;
   assign at_last = (idx_ff == (q_head.count - 2'd1));
   assign q_pop   = take && at_last;
   assign idx_in  = at_last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (load_ok) begin
         rsp_valid_ff <= take;
         if (take) begin
            idx_ff <= idx_in;
         end
      end
   end

   // Hold the payload while the receiver stalls
   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff <= q_head.bytes[idx_ff];
         last_ff     <= at_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> hw/rtl/url_form_name_encoder_core.sv
// URL form name encoder: one name byte in, zero to three encoded bytes out.
// Channels: req_ (data_byte, last_byte) in, rsp_ (out_byte, last_of_run) out,
// both valid/ready; a transfer happens when valid and ready are both high.
// A byte accepted on req_ is classified at once and stored as a record of
// up to three output bytes in a small queue; its first result byte then
// passes to rsp_ through the result register. Bytes that give no output (?, +,
// = and collapsed blanks) only update the flags and never reach the queue.
// Throughput: the result register sends one byte per cycle while rsp_ready is
// high; an item yields 3 bytes if escaped (%XX), 2 behind a separator once
// output has started, 1 otherwise; zero-output bytes take only an input slot.
// req_ready drops only when the queue is full, so input keeps flowing while a
// result waits in the output register.
// Reset (synchronous, active high) clears the flags, empties the queue and
// drops rsp_valid; there is no clearing pass. When the receiver stalls the
// result register holds its byte and the queue fills, then req_ready falls.
// Depends on ufne_pkg, ufne_front, ufne_queue and ufne_back.

module url_form_name_encoder_core #(
   parameter int unsigned QueueDepth = ufne_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   ufne_pkg::queue_status_type q_status;
   ufne_pkg::entry_type        push_entry;
   ufne_pkg::entry_type        head_entry;
   logic                       q_push;
   logic                       q_pop;

   ufne_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   ufne_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   ufne_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_head          (head_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Never push into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   // Never pop an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // Queued records always hold one to three bytes
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (head_entry.count != 2'd0))
      else $error("empty record in queue");

   // A record leaves the queue only with its final byte
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_valid && rsp_last_of_run))
      else $error("record popped without final byte");

   // Nothing is offered in the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
